@@ rtl/xfq_pkg.sv @@
// Package: constants, codes and types shared by the xor filter query block.
package xfq_pkg;

  localparam logic [63:0] GOLDEN_INIT = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] BYTE_MIXER  = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] FINAL_MIXER = 64'h94d049bb133111eb;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_KEY   = 2'd1;
  localparam logic [1:0] OP_EMPTY = 2'd2;

  localparam logic [1:0] REG_FP_BITS   = 2'd0;
  localparam logic [1:0] REG_SEED      = 2'd1;
  localparam logic [1:0] REG_SEG_LEN   = 2'd2;
  localparam logic [1:0] REG_TBL_BYTES = 2'd3;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

@@ rtl/xfq_mul64.sv @@
// Iterative 64x64 to 128-bit multiplier built on one registered 32x32 multiplier.
module xfq_mul64 (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [63:0]       op_a,
  input  logic [63:0]       op_b,
  output logic [127:0]      product,
  output xfq_pkg::mul_stat_t stat
);
  import xfq_pkg::*;

  localparam logic [2:0] LAST_STEP = 3'd4;

  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [63:0]  pp_r;
  logic [127:0] acc_r;
  logic [2:0]   cnt_r;
  logic         busy_r;
  logic         done_r;
  logic [31:0]  pa;
  logic [31:0]  pb;
  logic [127:0] addend;

  assign pa = cnt_r[1] ? a_r[63:32] : a_r[31:0];
  assign pb = cnt_r[0] ? b_r[63:32] : b_r[31:0];

  always_comb begin
    unique case (cnt_r)
      3'd1:    addend = {64'd0, pp_r};
      3'd2:    addend = {32'd0, pp_r, 32'd0};
      3'd3:    addend = {32'd0, pp_r, 32'd0};
      3'd4:    addend = {pp_r, 64'd0};
      default: addend = 128'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      done_r <= busy_r && (cnt_r == LAST_STEP);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 3'd0;
      end else if (busy_r && (cnt_r == LAST_STEP)) begin
        busy_r <= 1'b0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= op_a;
      b_r   <= op_b;
      acc_r <= 128'd0;
    end else if (busy_r) begin
      pp_r  <= 64'(pa) * 64'(pb);
      acc_r <= acc_r + addend;
    end
  end

  assign product   = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

@@ rtl/xor_filter_membership_query.sv @@
// Top level: three-wise binary fuse filter membership query over a packed table.
//
// Input channel (in_valid/in_ready) carries one item per handshake:
//   opcode 0 writes in_data_byte to the packed table at in_table_address;
//   opcode 1 streams a key byte; in_key_last marks the end of the key;
//   opcode 2 queries the empty key; opcode 3 is dropped.
// Each key byte runs one 64x64 multiply-fold on the shared multiplier, which
// builds the product from four 32x32 partial products.
// A query adds a final mix, three range reductions (each on the same multiplier)
// and three fields of five table bytes each, read one byte a cycle from the
// table memory.
// Result channel (out_valid/out_ready) carries maybe_member and key_fingerprint,
// one item per query. The result sits in an output register; the block takes no
// items while it waits and holds a finished query until the register is free.
// Configuration is an APB-style port; registers at byte addresses 0,4,8,12.
// Reset clears control state, sets fp_bits to 8 and clears the other registers;
// table contents are undefined until written.
module xor_filter_membership_query #(
  parameter int TABLE_DEPTH_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_table_address,
  input  logic [7:0]  in_data_byte,
  input  logic        in_key_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_maybe_member,
  output logic [31:0] out_key_fingerprint,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import xfq_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH_BYTES);
  localparam logic [24:0] DEPTH_C = 25'(TABLE_DEPTH_BYTES);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_BYTE = 4'd1;
  localparam logic [3:0] ST_FIN  = 4'd2;
  localparam logic [3:0] ST_RR0  = 4'd3;
  localparam logic [3:0] ST_RR1  = 4'd4;
  localparam logic [3:0] ST_RR2  = 4'd5;
  localparam logic [3:0] ST_FA   = 4'd6;
  localparam logic [3:0] ST_RD   = 4'd7;
  localparam logic [3:0] ST_FLD  = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  logic [5:0]  fp_bits_r;
  logic [31:0] seed_r;
  logic [17:0] seg_r;
  logic [16:0] tbytes_r;

  logic [3:0]  state_r;
  logic [3:0]  state_nxt;
  logic [63:0] hash_r;
  logic        inside_r;
  logic        last_r;
  logic [63:0] hfin_r;
  logic [31:0] fp_r;
  logic [19:0] slot_r [3];
  logic [1:0]  f_r;
  logic [2:0]  j_r;
  logic [24:0] bit_r;
  logic [39:0] raw_r;
  logic        rd_ok_r;
  logic [7:0]  mem_q_r;
  logic [31:0] accf_r;
  logic        out_valid_r;
  logic        out_maybe_r;
  logic [31:0] out_fp_r;

  logic [7:0]  tbl_mem [TABLE_DEPTH_BYTES];

  logic         in_acc;
  logic         cfg_wr;
  logic         mul_start;
  logic [63:0]  mul_a;
  logic [63:0]  mul_b;
  logic [127:0] mul_p;
  mul_stat_t    mul_st;
  logic [63:0]  fold;
  logic [63:0]  hi;
  logic [63:0]  start_hash;
  logic [5:0]  fw;
  logic [31:0] mask;
  logic [31:0] fp_raw;
  logic [24:0] rd_idx;
  logic [24:0] wr_idx;
  logic        tbl_we;
  logic        out_load;
  logic [2:0]  cap_j;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign fold      = mul_p[127:64] ^ mul_p[63:0];
  assign hi        = mul_p[127:64];
  assign start_hash = {32'd0, seed_r} ^ GOLDEN_INIT;
  assign fw        = (fp_bits_r >= 6'd32) ? 6'd32 : fp_bits_r;
  assign mask      = 32'((33'd1 << fw) - 33'd1);
  assign fp_raw    = fold[31:0] & mask;
  assign rd_idx    = 25'(bit_r[24:3]) + 25'(j_r);
  assign wr_idx    = {9'd0, in_table_address};
  assign tbl_we    = in_acc && (in_opcode == OP_WRITE) && (wr_idx < DEPTH_C);
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign cap_j     = j_r - 3'd1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fp_bits_r <= 6'd8;
      seed_r    <= 32'd0;
      seg_r     <= 18'd0;
      tbytes_r  <= 17'd0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_FP_BITS:   fp_bits_r <= pwdata[5:0];
        REG_SEED:      seed_r    <= pwdata;
        REG_SEG_LEN:   seg_r     <= pwdata[17:0];
        REG_TBL_BYTES: tbytes_r  <= pwdata[16:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FP_BITS:   prdata = {26'd0, fp_bits_r};
      REG_SEED:      prdata = seed_r;
      REG_SEG_LEN:   prdata = {14'd0, seg_r};
      REG_TBL_BYTES: prdata = {15'd0, tbytes_r};
    endcase
  end

  xfq_mul64 u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .product (mul_p),
    .stat    (mul_st)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    mul_start = 1'b0;
    mul_a     = fold;
    mul_b     = FINAL_MIXER;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_opcode == OP_KEY)) begin
          mul_start = 1'b1;
          mul_a     = (inside_r ? hash_r : start_hash) ^ {56'd0, in_data_byte};
          mul_b     = BYTE_MIXER;
          state_nxt = ST_BYTE;
        end else if (in_acc && (in_opcode == OP_EMPTY)) begin
          mul_start = 1'b1;
          mul_a     = start_hash;
          state_nxt = ST_FIN;
        end
      end
      ST_BYTE: begin
        if (mul_st.done) begin
          mul_start = last_r;
          state_nxt = last_r ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        mul_b = {46'd0, seg_r};
        if (mul_st.done) begin
          mul_start = 1'b1;
          state_nxt = ST_RR0;
        end
      end
      ST_RR0: begin
        mul_a = {hfin_r[20:0], hfin_r[63:21]};
        mul_b = {46'd0, seg_r};
        if (mul_st.done) begin
          mul_start = 1'b1;
          state_nxt = ST_RR1;
        end
      end
      ST_RR1: begin
        mul_a = {hfin_r[41:0], hfin_r[63:42]};
        mul_b = {46'd0, seg_r};
        if (mul_st.done) begin
          mul_start = 1'b1;
          state_nxt = ST_RR2;
        end
      end
      ST_RR2: begin
        if (mul_st.done) state_nxt = ST_FA;
      end
      ST_FA:   state_nxt = ST_RD;
      ST_RD: begin
        if (j_r == 3'd5) state_nxt = ST_FLD;
      end
      ST_FLD:  state_nxt = (f_r == 2'd2) ? ST_DONE : ST_FA;
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      inside_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE && in_acc && in_opcode == OP_KEY) inside_r <= 1'b1;
      if (state_r == ST_FIN && mul_st.done) inside_r <= 1'b0;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc) last_r <= in_key_last;
    if (state_r == ST_BYTE && mul_st.done) hash_r <= fold;
    if (state_r == ST_FIN && mul_st.done) begin
      hfin_r <= fold;
      fp_r   <= (fp_raw == 32'd0) ? 32'd1 : fp_raw;
    end
    if (state_r == ST_RR0 && mul_st.done) slot_r[0] <= hi[19:0];
    if (state_r == ST_RR1 && mul_st.done) slot_r[1] <= hi[19:0] + {2'd0, seg_r};
    if (state_r == ST_RR2 && mul_st.done) begin
      slot_r[2] <= hi[19:0] + {1'b0, seg_r, 1'b0};
      f_r       <= 2'd0;
      accf_r    <= 32'd0;
    end
    if (state_r == ST_FA) begin
      bit_r <= 25'(slot_r[f_r] * fw);
      j_r   <= 3'd0;
    end
    if (state_r == ST_RD) begin
      j_r     <= j_r + 3'd1;
      rd_ok_r <= (rd_idx < {8'd0, tbytes_r}) && (rd_idx < DEPTH_C);
      if (j_r != 3'd0) raw_r[8*cap_j +: 8] <= rd_ok_r ? mem_q_r : 8'd0;
    end
    if (state_r == ST_FLD) begin
      accf_r <= accf_r ^ (32'(raw_r >> bit_r[2:0]) & mask);
      f_r    <= f_r + 2'd1;
    end
    if (out_load) begin
      out_maybe_r <= (tbytes_r != 17'd0) && (accf_r == fp_r);
      out_fp_r    <= fp_r;
    end
  end

  // packed table
  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[wr_idx[AW-1:0]] <= in_data_byte;
    mem_q_r <= tbl_mem[rd_idx[AW-1:0]];
  end

  assign out_valid           = out_valid_r;
  assign out_maybe_member    = out_maybe_r;
  assign out_key_fingerprint = out_fp_r;

  a_fp_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_fp_r != 32'd0))
    else $error("zero fingerprint reported");

  a_empty_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && tbytes_r == 17'd0) |-> !out_maybe_r)
    else $error("match reported on empty filter");

  a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_st.done |-> (state_r == ST_BYTE || state_r == ST_FIN || state_r == ST_RR0 ||
                     state_r == ST_RR1 || state_r == ST_RR2))
    else $error("multiplier finished outside a waiting state");

  a_key_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_opcode == OP_KEY || in_opcode == OP_EMPTY)) |=> (state_r != ST_IDLE))
    else $error("key item did not start hashing");

endmodule

@@ test/tb.sv @@
// Testbench: xor filter query block checked against a bit-exact predictor.
`timescale 1ns / 100ps

module tb;
  import xfq_pkg::*;

  localparam int DEPTH = 65536;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        last;
  } item_t;

  typedef struct packed {
    logic        member;
    logic [31:0] fp;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_opcode = OP_WRITE;
  logic [15:0] in_table_address = '0;
  logic [7:0]  in_data_byte = '0;
  logic        in_key_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_maybe_member;
  logic [31:0] out_key_fingerprint;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  xor_filter_membership_query dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode),
    .in_table_address(in_table_address), .in_data_byte(in_data_byte),
    .in_key_last(in_key_last),
    .out_valid(out_valid), .out_ready(out_ready), .out_maybe_member(out_maybe_member),
    .out_key_fingerprint(out_key_fingerprint),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // register copies
  logic [5:0]  cfg_fp = 6'd8;
  logic [31:0] cfg_seed = '0;
  logic [17:0] cfg_seg = '0;
  logic [16:0] cfg_tbytes = '0;

  // predictor state
  bit [7:0]    table_image [DEPTH];
  logic [63:0] key_hash = '0;
  bit          key_open = 1'b0;

  // stimulus planning state
  bit [7:0]    table_plan [DEPTH];
  bit          written [DEPTH];
  bit          plan_in_key = 1'b0;
  int          n_items = 0;

  item_t   pending_items [$];
  answer_t expected_answers [$];
  item_t   next_item;
  answer_t got_answer;
  int      errors = 0;
  int      cyc = 0;
  logic    calm;

  assign calm = (cyc % 5000) < 900;

  function automatic logic [63:0] fold(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[127:64] ^ p[63:0];
  endfunction

  function automatic logic [63:0] mul_hi(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[127:64];
  endfunction

  function automatic int fwidth();
    return (cfg_fp >= 6'd32) ? 32 : int'(cfg_fp);
  endfunction

  function automatic logic [31:0] fmask();
    int w;
    w = fwidth();
    return (w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
  endfunction

  function automatic logic [31:0] fp_of(input logic [63:0] h);
    logic [31:0] f;
    f = h[31:0] & fmask();
    return (f == 32'd0) ? 32'd1 : f;
  endfunction

  function automatic logic [63:0] slot_of(input logic [63:0] h, input int k);
    logic [63:0] x, seg;
    seg = {46'd0, cfg_seg};
    case (k)
      0: x = h;
      1: x = {h[20:0], h[63:21]};
      default: x = {h[41:0], h[63:42]};
    endcase
    return mul_hi(x, seg) + seg * 64'(k);
  endfunction

  function automatic logic [7:0] table_at(input logic [63:0] idx, input bit plan);
    if (idx >= {47'd0, cfg_tbytes} || idx >= 64'(DEPTH)) return 8'd0;
    return plan ? table_plan[idx[15:0]] : table_image[idx[15:0]];
  endfunction

  function automatic logic [31:0] field_at(input logic [63:0] slot, input bit plan);
    logic [63:0] bitpos, base;
    logic [39:0] raw;
    int i;
    bitpos = slot * 64'(fwidth());
    base = bitpos >> 3;
    raw = '0;
    for (i = 0; i < 5; i++) raw[8*i +: 8] = table_at(base + 64'(i), plan);
    raw = raw >> bitpos[2:0];
    return raw[31:0] & fmask();
  endfunction

  function automatic answer_t answer_of(input logic [63:0] h, input bit plan);
    answer_t a;
    logic [31:0] acc;
    acc = field_at(slot_of(h, 0), plan) ^ field_at(slot_of(h, 1), plan)
        ^ field_at(slot_of(h, 2), plan);
    a.fp = fp_of(h);
    a.member = (cfg_tbytes != 17'd0) && (acc == a.fp);
    return a;
  endfunction

  task automatic apply_item(input item_t it);
    case (it.op)
      OP_WRITE: begin
        table_image[it.addr] = it.data;
      end
      OP_KEY: begin
        if (!key_open) begin
          key_hash = {32'd0, cfg_seed} ^ GOLDEN_INIT;
          key_open = 1'b1;
        end
        key_hash = fold(key_hash ^ {56'd0, it.data}, BYTE_MIXER);
        if (it.last) begin
          expected_answers.insert(expected_answers.size(),
                                  answer_of(fold(key_hash, FINAL_MIXER), 1'b0));
          key_open = 1'b0;
        end
      end
      OP_EMPTY: begin
        key_hash = {32'd0, cfg_seed} ^ GOLDEN_INIT;
        expected_answers.insert(expected_answers.size(),
                                answer_of(fold(key_hash, FINAL_MIXER), 1'b0));
        key_open = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    errors++;
    $display("mismatch %0s: got %h expected %h", what, got, want);
  endtask

  function automatic bit stall_now();
    return !calm && ($urandom_range(0, 99) < 22);
  endfunction

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // input driver
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      apply_item({in_opcode, in_table_address, in_data_byte, in_key_last});
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_items.size() != 0 && !stall_now()) begin
        next_item = pending_items.pop_front();
        in_valid <= 1'b1;
        in_opcode <= next_item.op;
        in_table_address <= next_item.addr;
        in_data_byte <= next_item.data;
        in_key_last <= next_item.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    out_ready <= !stall_now();
    if (rst_n && out_valid && out_ready) begin
      if (expected_answers.size() == 0) begin
        flag_mismatch("unexpected result", out_key_fingerprint, 32'd0);
      end else begin
        got_answer = expected_answers.pop_front();
        if (out_maybe_member !== got_answer.member)
          flag_mismatch("maybe_member", {31'd0, out_maybe_member}, {31'd0, got_answer.member});
        if (out_key_fingerprint !== got_answer.fp)
          flag_mismatch("key_fingerprint", out_key_fingerprint, got_answer.fp);
      end
    end
  end

  task automatic apb_xfer(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [31:0] cfg_value(input logic [1:0] idx);
    case (idx)
      REG_FP_BITS: return {26'd0, cfg_fp};
      REG_SEED:    return cfg_seed;
      REG_SEG_LEN: return {14'd0, cfg_seg};
      default:     return {15'd0, cfg_tbytes};
    endcase
  endfunction

  task automatic cfg_check(input logic [1:0] idx);
    logic [31:0] rd;
    apb_xfer(1'b0, idx, 32'd0, rd);
    if (rd !== cfg_value(idx)) flag_mismatch("register readback", rd, cfg_value(idx));
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] rd;
    apb_xfer(1'b1, idx, val, rd);
    case (idx)
      REG_FP_BITS: cfg_fp = val[5:0];
      REG_SEED:    cfg_seed = val;
      REG_SEG_LEN: cfg_seg = val[17:0];
      default:     cfg_tbytes = val[16:0];
    endcase
    cfg_check(idx);
  endtask

  task automatic push_item(input logic [1:0] op, input logic [15:0] addr,
                           input logic [7:0] data, input logic last);
    pending_items.insert(pending_items.size(), {op, addr, data, last});
    case (op)
      OP_WRITE: begin
        table_plan[addr] = data;
        written[addr] = 1'b1;
      end
      OP_KEY:   plan_in_key = !last;
      OP_EMPTY: plan_in_key = 1'b0;
      default: ;
    endcase
    if (op != OP_NONE) n_items++;
  endtask

  // write every byte a query could read that has not been loaded yet
  task automatic prefill();
    logic [63:0] reach;
    int need, a;
    reach = (({46'd0, cfg_seg} * 64'd3 * 64'(fwidth())) >> 3) + 64'd5;
    need = DEPTH;
    if (reach < 64'(need)) need = int'(reach);
    if (int'(cfg_tbytes) < need) need = int'(cfg_tbytes);
    for (a = 0; a < need; a++)
      if (!written[a]) push_item(OP_WRITE, 16'(a), 8'($urandom), 1'($urandom));
  endtask

  // rewrite one field so the key's three fields XOR to its fingerprint
  task automatic plant_hit(input logic [63:0] h);
    logic [63:0] s [3];
    logic [63:0] p, bitpos, hi_byte, b, g;
    logic [31:0] target;
    logic [7:0] nb;
    int w, k, j;
    w = fwidth();
    if (w == 0 || cfg_tbytes == 17'd0) return;
    for (k = 0; k < 3; k++) s[k] = slot_of(h, k);
    if (s[0] == s[1] && s[1] != s[2]) p = s[2];
    else if (s[0] == s[2] && s[0] != s[1]) p = s[1];
    else p = s[0];
    target = fp_of(h);
    for (k = 0; k < 3; k++)
      if (s[k] != p) target ^= field_at(s[k], 1'b1);
    bitpos = p * 64'(w);
    hi_byte = (bitpos + 64'(w) - 64'd1) >> 3;
    if (hi_byte >= {47'd0, cfg_tbytes} || hi_byte >= 64'(DEPTH)) return;
    for (b = bitpos >> 3; b <= hi_byte; b++) begin
      nb = table_plan[b[15:0]];
      for (j = 0; j < 8; j++) begin
        g = b * 64'd8 + 64'(j);
        if (g >= bitpos && g < bitpos + 64'(w)) nb[j] = target[5'(g - bitpos)];
      end
      push_item(OP_WRITE, b[15:0], nb, 1'($urandom));
    end
  endtask

  task automatic send_key(input int n, input bit hit);
    logic [7:0] kb [8];
    logic [63:0] h;
    int i;
    if (plan_in_key) push_item(OP_EMPTY, 16'($urandom), 8'($urandom), 1'($urandom));
    h = {32'd0, cfg_seed} ^ GOLDEN_INIT;
    for (i = 0; i < n; i++) begin
      kb[i] = 8'($urandom);
      h = fold(h ^ {56'd0, kb[i]}, BYTE_MIXER);
    end
    h = fold(h, FINAL_MIXER);
    if (hit) plant_hit(h);
    if (n == 0) push_item(OP_EMPTY, 16'($urandom), 8'($urandom), 1'($urandom));
    for (i = 0; i < n; i++) push_item(OP_KEY, 16'($urandom), kb[i], i == n - 1);
  endtask

  task automatic random_step();
    int r, n, i;
    r = $urandom_range(0, 99);
    if (r < 48) begin
      send_key($urandom_range(1, 6), $urandom_range(0, 2) == 0);
    end else if (r < 58) begin
      send_key(0, $urandom_range(0, 1) == 1);
    end else if (r < 74) begin
      push_item(OP_WRITE, 16'($urandom), 8'($urandom), 1'($urandom));
    end else if (r < 82) begin
      push_item(OP_NONE, 16'($urandom), 8'($urandom), 1'($urandom));
    end else if (r < 92) begin
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) push_item(OP_KEY, 16'($urandom), 8'($urandom), 1'b0);
    end else if (r < 96 && plan_in_key) begin
      push_item(OP_KEY, 16'($urandom), 8'($urandom), 1'b1);
    end else begin
      push_item(OP_EMPTY, 16'($urandom), 8'($urandom), 1'b1);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_answers.size() != 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic run_phase(input logic [5:0] fpb, input logic [31:0] seed,
                           input logic [17:0] seg, input logic [16:0] tbytes,
                           input int quota, input bit directed);
    int start;
    cfg_write(REG_FP_BITS, {26'd0, fpb});
    cfg_write(REG_SEED, seed);
    cfg_write(REG_SEG_LEN, {14'd0, seg});
    cfg_write(REG_TBL_BYTES, {15'd0, tbytes});
    @(negedge clk);
    prefill();
    if (directed) begin
      send_key(1, 1'b1);
      send_key(0, 1'b1);
      send_key(3, 1'b1);
      send_key(6, 1'b1);
      push_item(OP_KEY, 16'h0000, 8'hFF, 1'b0);
      push_item(OP_KEY, 16'hFFFF, 8'h00, 1'b1);
    end
    start = n_items;
    while (n_items - start < quota) random_step();
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    cfg_check(REG_FP_BITS);
    cfg_check(REG_SEED);
    cfg_check(REG_SEG_LEN);
    cfg_check(REG_TBL_BYTES);
    @(negedge clk);
    // reset settings: empty filter, zero segments
    prefill();
    push_item(OP_EMPTY, 16'h0000, 8'h00, 1'b0);
    push_item(OP_EMPTY, 16'hFFFF, 8'hFF, 1'b1);
    push_item(OP_KEY, 16'h0000, 8'h00, 1'b1);
    push_item(OP_KEY, 16'hFFFF, 8'hFF, 1'b1);
    push_item(OP_KEY, 16'h1234, 8'h5A, 1'b0);
    push_item(OP_KEY, 16'h4321, 8'hA5, 1'b0);
    push_item(OP_EMPTY, 16'h0000, 8'h00, 1'b1);
    push_item(OP_WRITE, 16'hFFFF, 8'hFF, 1'b1);
    push_item(OP_WRITE, 16'hFFFF, 8'h00, 1'b0);
    push_item(OP_NONE, 16'hFFFF, 8'hFF, 1'b1);
    push_item(OP_NONE, 16'h0000, 8'h00, 1'b0);
    send_key(3, 1'b0);
    wait_drained();

    run_phase(6'd8, 32'($urandom), 18'd3, 17'd16, 110, 1'b1);
    run_phase(6'd1, 32'h0000_0000, 18'd0, 17'd64, 110, 1'b0);
    run_phase(6'd32, 32'hFFFF_FFFF, 18'd20, 17'd2000, 110, 1'b0);
    run_phase(6'd0, 32'($urandom), 18'd7, 17'd50, 100, 1'b0);
    run_phase(6'd63, 32'($urandom), 18'd174762, 17'd200, 120, 1'b0);
    run_phase(6'd33, 32'($urandom), 18'd40, 17'h10000, 120, 1'b0);
    run_phase(6'd5, 32'($urandom), 18'd1000, 17'd0, 100, 1'b0);
    run_phase(6'd17, 32'($urandom), 18'd30, 17'h1FFFF, 120, 1'b0);
    run_phase(6'd12, 32'($urandom), 18'h3FFFF, 17'd300, 110, 1'b0);
    run_phase(6'($urandom_range(1, 32)), 32'($urandom), 18'($urandom_range(1, 60)),
              17'($urandom_range(16, 600)), 120, 1'b0);

    if (errors == 0 && expected_answers.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/xfq_pkg.sv
rtl/xfq_mul64.sv
rtl/xor_filter_membership_query.sv
test/tb.sv
